### hw/rtl/brmm_pkg.sv
// ----------------------------------------------------------------------------
// Balanced rank mesh mapper package
// Shared constants, request codes and the split-parameter bundle.
// ----------------------------------------------------------------------------
package brmm_pkg;

    // Configuration limits
    localparam int unsigned MAX_RANKS  = 4096;
    localparam int unsigned MAX_GROUPS = 64;

    // Request codes
    localparam logic [1:0] REQ_LOCATE = 2'd0;
    localparam logic [1:0] REQ_RANK   = 2'd1;
    localparam logic [1:0] REQ_SIZE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_GLOBAL = 2'd0;
    localparam logic [1:0] CFG_RUN    = 2'd1;
    localparam logic [1:0] CFG_CHAIN  = 2'd2;

    // Split-parameter engine states
    typedef enum logic [2:0] {
        PREP_IDLE,
        PREP_DIV_RUN,
        PREP_DIV_A,
        PREP_DIV_B,
        PREP_EDGE
    } t_prep_state;

    // Split parameters derived from the configuration
    typedef struct packed {
        logic        cfg_ok;
        logic [12:0] g;
        logic [6:0]  r;
        logic [6:0]  c;
        logic [13:0] q1;
        logic [13:0] q1p;
        logic [6:0]  m1;
        logic [13:0] edge1;
        logic [13:0] qa;
        logic [13:0] qap;
        logic [6:0]  ma;
        logic [13:0] edgea;
        logic [13:0] qb;
        logic [13:0] qbp;
        logic [6:0]  mb;
        logic [13:0] edgeb;
    } t_prep;

endpackage

### hw/rtl/brmm_prep.sv
// ----------------------------------------------------------------------------
// Split-parameter engine
// Holds the configuration and derives quotients, remainders and edges of the
// run split and of both chain split sizes with one bit-serial divider.
// ----------------------------------------------------------------------------
module brmm_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    output logic               o_busy,
    output brmm_pkg::t_prep    o_prep
);
    import brmm_pkg::*;

    localparam logic [3:0] DIV_LAST = 4'd13;

    t_prep_state r_state, n_state;
    logic [12:0] r_g;
    logic [6:0]  r_r, r_c;
    logic [3:0]  r_cnt;
    logic [6:0]  r_rem;
    logic [13:0] r_quo;
    logic [13:0] r_q1, r_qa, r_qb;
    logic [6:0]  r_m1, r_ma, r_mb;
    logic [13:0] r_edge1, r_edgea, r_edgeb;
    logic        r_cfg_ok;

    logic [13:0] dvd;
    logic [6:0]  dsr;
    logic [7:0]  trial;
    logic        ge;
    logic [6:0]  rem_n;
    logic [13:0] quo_n;
    logic        done;
    logic [20:0] prod1, proda, prodb;

    // Pick operands and run one restoring step
    always_comb begin
        case (r_state)
            PREP_DIV_A: dvd = r_q1;
            PREP_DIV_B: dvd = r_q1 + 14'd1;
            default:    dvd = {1'b0, r_g};
        endcase
        dsr   = (r_state == PREP_DIV_RUN) ? r_r : r_c;
        trial = {r_rem, dvd[DIV_LAST - r_cnt]};
        ge    = trial >= {1'b0, dsr};
        rem_n = ge ? 7'(trial - {1'b0, dsr}) : trial[6:0];
        quo_n = {r_quo[12:0], ge};
        done  = r_cnt == DIV_LAST;
        prod1 = 21'(r_m1) * 21'(r_q1 + 14'd1);
        proda = 21'(r_ma) * 21'(r_qa + 14'd1);
        prodb = 21'(r_mb) * 21'(r_qb + 14'd1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            PREP_IDLE:    n_state = PREP_IDLE;
            PREP_DIV_RUN: if (done) n_state = PREP_DIV_A;
            PREP_DIV_A:   if (done) n_state = PREP_DIV_B;
            PREP_DIV_B:   if (done) n_state = PREP_EDGE;
            PREP_EDGE:    n_state = PREP_IDLE;
            default:      n_state = PREP_IDLE;
        endcase
        if (i_cfg_valid) begin
            n_state = PREP_DIV_RUN;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PREP_DIV_RUN;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_g     <= 13'd1;
            r_r     <= 7'd1;
            r_c     <= 7'd1;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cnt <= '0;
                r_rem <= '0;
                case (i_cfg_index)
                    CFG_GLOBAL: r_g <= i_cfg_data;
                    CFG_RUN:    r_r <= i_cfg_data[6:0];
                    CFG_CHAIN:  r_c <= i_cfg_data[6:0];
                    default:    ;
                endcase
            end else if (r_state inside {PREP_DIV_RUN, PREP_DIV_A, PREP_DIV_B}) begin
                if (done) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                end else begin
                    r_cnt <= r_cnt + 4'd1;
                    r_rem <= rem_n;
                end
            end
        end
    end

    // Divider results and edges
    always_ff @(posedge i_clk) begin
        r_quo <= done ? '0 : quo_n;
        case (r_state)
            PREP_DIV_RUN: if (done) begin
                r_q1 <= quo_n;
                r_m1 <= rem_n;
            end
            PREP_DIV_A: if (done) begin
                r_qa <= quo_n;
                r_ma <= rem_n;
            end
            PREP_DIV_B: if (done) begin
                r_qb <= quo_n;
                r_mb <= rem_n;
            end
            PREP_EDGE: begin
                r_edge1  <= prod1[13:0];
                r_edgea  <= proda[13:0];
                r_edgeb  <= prodb[13:0];
                r_cfg_ok <= (r_g != '0) && (32'(r_g) <= MAX_RANKS) &&
                            (r_r != '0) && (32'(r_r) <= MAX_GROUPS) &&
                            (r_c != '0) && (32'(r_c) <= MAX_GROUPS);
            end
            default: ;
        endcase
    end

    assign o_busy = r_state != PREP_IDLE;

    always_comb begin
        o_prep.cfg_ok = r_cfg_ok;
        o_prep.g      = r_g;
        o_prep.r      = r_r;
        o_prep.c      = r_c;
        o_prep.q1     = r_q1;
        o_prep.q1p    = r_q1 + 14'd1;
        o_prep.m1     = r_m1;
        o_prep.edge1  = r_edge1;
        o_prep.qa     = r_qa;
        o_prep.qap    = r_qa + 14'd1;
        o_prep.ma     = r_ma;
        o_prep.edgea  = r_edgea;
        o_prep.qb     = r_qb;
        o_prep.qbp    = r_qb + 14'd1;
        o_prep.mb     = r_mb;
        o_prep.edgeb  = r_edgeb;
    end

endmodule

### hw/rtl/brmm_pipe.sv
// ----------------------------------------------------------------------------
// Request pipeline
// Nine register stages: run locate divide, coordinate-to-rank arithmetic,
// chain locate divide, and result formatting. Whole pipe freezes on stall.
// ----------------------------------------------------------------------------
module brmm_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brmm_pkg::t_prep   i_prep,
    input  logic              i_hold,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [11:0]       i_flat_rank,
    input  logic [5:0]        i_run_index,
    input  logic [5:0]        i_chain_index,
    input  logic [11:0]       i_local_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [5:0]        o_run_coord,
    output logic [5:0]        o_chain_coord,
    output logic [11:0]       o_local_rank,
    output logic [11:0]       o_rank_out,
    output logic [12:0]       o_group_ranks,
    output logic              o_error
);
    import brmm_pkg::*;

    localparam int NUM_STAGES = 9;

    typedef struct packed {
        logic [1:0]  req;
        logic        err;
        logic [11:0] num;
        logic [13:0] dsr;
        logic [5:0]  quo;
        logic [6:0]  base;
        logic [5:0]  ri;
        logic [5:0]  ci;
        logic [11:0] li;
        logic [12:0] rstart;
        logic [13:0] qx;
        logic [6:0]  mx;
        logic [13:0] chsz;
        logic [5:0]  rc;
        logic [5:0]  cc;
        logic [11:0] lr;
        logic [11:0] ro;
        logic [12:0] gr;
    } t_item;

    t_item                 r_st [NUM_STAGES];
    t_item                 n_st [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_vld;
    logic                  adv;
    logic                  accept;

    // One restoring step: {quotient bit, new remainder}
    function automatic logic [12:0] div_step(logic [11:0] n, logic [13:0] d,
                                             logic [2:0] k);
        logic [19:0] sh;
        sh = {6'b0, d} << k;
        if ({8'b0, n} >= sh) begin
            return {1'b1, n - sh[11:0]};
        end
        return {1'b0, n};
    endfunction

    // Two quotient bits per stage
    function automatic t_item div_pair(t_item it, logic [2:0] k_hi);
        logic [12:0] s;
        t_item       o;
        o     = it;
        s     = div_step(o.num, o.dsr, k_hi);
        o.quo = {o.quo[4:0], s[12]};
        o.num = s[11:0];
        s     = div_step(o.num, o.dsr, k_hi - 3'd1);
        o.quo = {o.quo[4:0], s[12]};
        o.num = s[11:0];
        return o;
    endfunction

    // Advance the pipe unless the result is held
    assign adv        = !(r_vld[NUM_STAGES-1] && i_out_stall);
    assign o_in_stall = !adv || i_hold;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        t_item       it;
        logic        lo;
        logic        big;
        logic [19:0] prod;
        logic [6:0]  sum;
        logic [13:0] edge_sel;

        // Stage 0: set up run locate, run start and chain split of the run
        it       = '0;
        it.req   = i_req_type;
        it.ri    = i_run_index;
        it.ci    = i_chain_index;
        it.li    = i_local_index;
        lo       = {2'b0, i_flat_rank} < i_prep.edge1;
        it.num   = lo ? i_flat_rank : i_flat_rank - i_prep.edge1[11:0];
        it.dsr   = lo ? i_prep.q1p : i_prep.q1;
        it.base  = lo ? '0 : i_prep.m1;
        big      = {1'b0, i_run_index} < i_prep.m1;
        prod     = 20'(i_run_index) * 20'(i_prep.q1);
        it.rstart = prod[12:0] + (big ? 13'(i_run_index) : 13'(i_prep.m1));
        it.qx    = big ? i_prep.qb : i_prep.qa;
        it.mx    = big ? i_prep.mb : i_prep.ma;
        it.err   = !i_prep.cfg_ok || (i_req_type > REQ_SIZE) ||
                   ((i_req_type == REQ_LOCATE) && ({1'b0, i_flat_rank} >= i_prep.g)) ||
                   ((i_req_type != REQ_LOCATE) &&
                    (({1'b0, i_run_index} >= i_prep.r) ||
                     ({1'b0, i_chain_index} >= i_prep.c)));
        n_st[0]  = it;

        // Stage 1: run divide, chain start and chain size
        it        = div_pair(r_st[0], 3'd5);
        big       = {1'b0, it.ci} < it.mx;
        prod      = 20'(it.ci) * 20'(it.qx);
        it.rstart = it.rstart + prod[12:0] + (big ? 13'(it.ci) : 13'(it.mx));
        it.chsz   = it.qx + 14'(big);
        n_st[1]   = it;

        // Stage 2: run divide, flat rank and coordinate checks
        it    = div_pair(r_st[1], 3'd3);
        it.ro = 12'(it.rstart + 13'(it.li));
        it.gr = it.chsz[12:0];
        if ((it.req == REQ_RANK) && ({2'b0, it.li} >= it.chsz)) begin
            it.err = 1'b1;
        end
        if ((it.req == REQ_SIZE) && (it.chsz == '0)) begin
            it.err = 1'b1;
        end
        n_st[2] = it;

        // Stage 3: run divide
        n_st[3] = div_pair(r_st[2], 3'd1);

        // Stage 4: set up chain locate inside the found run
        it       = r_st[3];
        sum      = it.base + 7'(it.quo);
        it.rc    = sum[5:0];
        big      = sum < i_prep.m1;
        edge_sel = big ? i_prep.edgeb : i_prep.edgea;
        lo       = {2'b0, it.num} < edge_sel;
        it.dsr   = lo ? (big ? i_prep.qbp : i_prep.qap) : (big ? i_prep.qb : i_prep.qa);
        it.base  = lo ? '0 : (big ? i_prep.mb : i_prep.ma);
        it.num   = lo ? it.num : it.num - edge_sel[11:0];
        it.quo   = '0;
        n_st[4]  = it;

        // Stages 5 to 7: chain divide
        n_st[5] = div_pair(r_st[4], 3'd5);
        n_st[6] = div_pair(r_st[5], 3'd3);
        n_st[7] = div_pair(r_st[6], 3'd1);

        // Stage 8: format the result, drop fields the request does not make
        it    = r_st[7];
        sum   = it.base + 7'(it.quo);
        it.cc = sum[5:0];
        it.lr = it.num;
        if (it.req != REQ_LOCATE) begin
            it.rc = '0;
            it.cc = '0;
            it.lr = '0;
        end
        if (it.req != REQ_RANK) begin
            it.ro = '0;
        end
        if (it.req != REQ_SIZE) begin
            it.gr = '0;
        end
        if (it.err) begin
            it.rc = '0;
            it.cc = '0;
            it.lr = '0;
            it.ro = '0;
            it.gr = '0;
        end
        n_st[8] = it;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], accept};
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st <= n_st;
        end
    end

    assign o_out_valid   = r_vld[NUM_STAGES-1];
    assign o_run_coord   = r_st[NUM_STAGES-1].rc;
    assign o_chain_coord = r_st[NUM_STAGES-1].cc;
    assign o_local_rank  = r_st[NUM_STAGES-1].lr;
    assign o_rank_out    = r_st[NUM_STAGES-1].ro;
    assign o_group_ranks = r_st[NUM_STAGES-1].gr;
    assign o_error       = r_st[NUM_STAGES-1].err;

endmodule

### hw/rtl/balanced_rank_mesh_mapper.sv
// ----------------------------------------------------------------------------
// Balanced rank mesh mapper
// Maps flat ranks to run/chain/local coordinates and back, and reports group
// sizes, for a balanced split of the rank space.
// ----------------------------------------------------------------------------
// Requests flow through a nine-stage pipeline and one request is accepted
// per cycle while neither an output stall nor a configuration update holds
// the input. A stall on the output freezes the whole pipeline.
// After reset and after every configuration write, a bit-serial divider
// derives the split parameters (three 14-step divides and one edge step);
// the input stalls while it runs and while a write is offered.
module balanced_rank_mesh_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_flat_rank,
    input  logic [5:0]  i_run_index,
    input  logic [5:0]  i_chain_index,
    input  logic [11:0] i_local_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_run_coord,
    output logic [5:0]  o_chain_coord,
    output logic [11:0] o_local_rank,
    output logic [11:0] o_rank_out,
    output logic [12:0] o_group_ranks,
    output logic        o_error
);
    import brmm_pkg::*;

    t_prep prep;
    logic  prep_busy;

    assign o_cfg_ready = 1'b1;

    // Derive split parameters from the configuration
    brmm_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (prep_busy),
        .o_prep      (prep)
    );

    // Answer requests
    brmm_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_prep        (prep),
        .i_hold        (prep_busy || i_cfg_valid),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_flat_rank   (i_flat_rank),
        .i_run_index   (i_run_index),
        .i_chain_index (i_chain_index),
        .i_local_index (i_local_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_run_coord   (o_run_coord),
        .o_chain_coord (o_chain_coord),
        .o_local_rank  (o_local_rank),
        .o_rank_out    (o_rank_out),
        .o_group_ranks (o_group_ranks),
        .o_error       (o_error)
    );

endmodule

### tb/brmm_checker.sv
// ----------------------------------------------------------------------------
// Balanced rank mesh mapper checker
// Watches the config, request and result channels, predicts each result from
// its own copy of the split registers, and compares the results in order.
// ----------------------------------------------------------------------------
module brmm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_flat_rank,
    input  logic [5:0]  i_run_index,
    input  logic [5:0]  i_chain_index,
    input  logic [11:0] i_local_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_run_coord,
    input  logic [5:0]  i_chain_coord,
    input  logic [11:0] i_local_rank,
    input  logic [11:0] i_rank_out,
    input  logic [12:0] i_group_ranks,
    input  logic        i_error,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import brmm_pkg::*;

    typedef struct packed {
        logic [5:0]  run_coord;
        logic [5:0]  chain_coord;
        logic [11:0] local_rank;
        logic [11:0] rank_out;
        logic [12:0] group_ranks;
        logic        error;
    } t_mapping;

    logic [12:0] mesh_size = 13'd1;
    logic [6:0]  run_groups = 7'd1;
    logic [6:0]  chain_groups = 7'd1;
    t_mapping    mapping_queue[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = mapping_queue.size();

    // Ranks in group idx of a balanced split of total over g groups
    function automatic int unsigned share_size(int unsigned total, int unsigned g,
                                               int unsigned idx);
        return total / g + ((idx < total % g) ? 1 : 0);
    endfunction

    // First rank of group idx
    function automatic int unsigned share_start(int unsigned total, int unsigned g,
                                                int unsigned idx);
        int unsigned rem;
        rem = total % g;
        return idx * (total / g) + ((idx < rem) ? idx : rem);
    endfunction

    // Group and offset of a rank within a split
    function automatic void share_locate(int unsigned rank, int unsigned total,
                                         int unsigned g, output int unsigned idx,
                                         output int unsigned off);
        int unsigned q;
        int unsigned rem;
        int unsigned boundary;
        q = total / g;
        rem = total % g;
        boundary = rem * (q + 1);
        if (rank < boundary) begin
            idx = rank / (q + 1);
            off = rank % (q + 1);
        end else if (q != 0) begin
            idx = rem + (rank - boundary) / q;
            off = (rank - boundary) % q;
        end else begin
            idx = 0;
            off = 0;
        end
    endfunction

    function automatic t_mapping map_request(logic [1:0] req, logic [11:0] rank,
                                             logic [5:0] ri, logic [5:0] ci,
                                             logic [11:0] li);
        t_mapping    res;
        int unsigned gs, rg, cg, run_idx, in_run, run_sz, ch_idx, in_chain, ch_sz;
        bit          cfg_ok;
        res = '0;
        gs = mesh_size;
        rg = run_groups;
        cg = chain_groups;
        cfg_ok = gs >= 1 && gs <= MAX_RANKS && rg >= 1 && rg <= MAX_GROUPS &&
                 cg >= 1 && cg <= MAX_GROUPS;
        if (!cfg_ok || !(req inside {REQ_LOCATE, REQ_RANK, REQ_SIZE})) begin
            res.error = 1'b1;
        end else if (req == REQ_LOCATE) begin
            if (rank >= gs) begin
                res.error = 1'b1;
            end else begin
                share_locate(rank, gs, rg, run_idx, in_run);
                run_sz = share_size(gs, rg, run_idx);
                share_locate(in_run, run_sz, cg, ch_idx, in_chain);
                res.run_coord   = run_idx[5:0];
                res.chain_coord = ch_idx[5:0];
                res.local_rank  = in_chain[11:0];
            end
        end else if (ri >= rg || ci >= cg) begin
            res.error = 1'b1;
        end else begin
            run_sz = share_size(gs, rg, ri);
            ch_sz  = share_size(run_sz, cg, ci);
            if (req == REQ_RANK) begin
                if (li >= ch_sz) begin
                    res.error = 1'b1;
                end else begin
                    in_run = share_start(gs, rg, ri) + share_start(run_sz, cg, ci) + li;
                    res.rank_out = in_run[11:0];
                end
            end else if (ch_sz == 0) begin
                res.error = 1'b1;
            end else begin
                res.group_ranks = ch_sz[12:0];
            end
        end
        return res;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin
        t_mapping want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                mapping_queue.push_back(map_request(i_req_type, i_flat_rank,
                                                    i_run_index, i_chain_index,
                                                    i_local_index));
            if (i_out_valid && !i_out_stall) begin
                if (mapping_queue.size() == 0) begin
                    $error("result with no request pending");
                    fail_count++;
                end else begin
                    want = mapping_queue.pop_front();
                    if (want.run_coord !== i_run_coord) begin
                        $error("run_coord: expected %0d, got %0d", want.run_coord, i_run_coord);
                        fail_count++;
                    end
                    if (want.chain_coord !== i_chain_coord) begin
                        $error("chain_coord: expected %0d, got %0d",
                               want.chain_coord, i_chain_coord);
                        fail_count++;
                    end
                    if (want.local_rank !== i_local_rank) begin
                        $error("local_rank: expected %0d, got %0d",
                               want.local_rank, i_local_rank);
                        fail_count++;
                    end
                    if (want.rank_out !== i_rank_out) begin
                        $error("rank_out: expected %0d, got %0d", want.rank_out, i_rank_out);
                        fail_count++;
                    end
                    if (want.group_ranks !== i_group_ranks) begin
                        $error("group_ranks: expected %0d, got %0d",
                               want.group_ranks, i_group_ranks);
                        fail_count++;
                    end
                    if (want.error !== i_error) begin
                        $error("error: expected %0d, got %0d", want.error, i_error);
                        fail_count++;
                    end
                end
            end
            // Track register writes; index beyond the chain register is dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GLOBAL: mesh_size    = i_cfg_data;
                    CFG_RUN:    run_groups   = i_cfg_data[6:0];
                    CFG_CHAIN:  chain_groups = i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/tb_balanced_rank_mesh_mapper.sv
// ----------------------------------------------------------------------------
// Balanced rank mesh mapper testbench
// Steps through a set of mesh splits, good and bad, and sends directed and
// random requests in bursts while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_balanced_rank_mesh_mapper;
    timeunit 1ns;
    timeprecision 1ps;
    import brmm_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_ITEMS = 125;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [11:0] i_flat_rank = '0;
    logic [5:0]  i_run_index = '0;
    logic [5:0]  i_chain_index = '0;
    logic [11:0] i_local_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [5:0]  o_run_coord;
    logic [5:0]  o_chain_coord;
    logic [11:0] o_local_rank;
    logic [11:0] o_rank_out;
    logic [12:0] o_group_ranks;
    logic        o_error;
    int          fail_count;
    int          pending;

    int unsigned mesh_size = 1;
    int unsigned run_groups = 1;
    int unsigned chain_groups = 1;
    int          idle_cycles = 0;
    int          burst_left = 0;

    balanced_rank_mesh_mapper u_dut (.*);

    brmm_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_stall(o_in_stall), .i_req_type,
        .i_flat_rank, .i_run_index, .i_chain_index, .i_local_index,
        .i_out_valid(o_out_valid), .i_out_stall, .i_run_coord(o_run_coord),
        .i_chain_coord(o_chain_coord), .i_local_rank(o_local_rank),
        .i_rank_out(o_rank_out), .i_group_ranks(o_group_ranks), .i_error(o_error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side: modes of none, random and periodic
    always @(posedge i_clk) begin
        int unsigned mode;
        int unsigned tick;
        if ((tick % 200) == 0)
            mode = $urandom_range(0, 2);
        tick++;
        case (mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 35);
            default: i_out_stall <= ((tick % 7) < 2);
        endcase
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("balanced_rank_mesh_mapper: mismatch");
            $finish;
        end
    end

    // Wait for all results, then for the pipeline to go quiet
    task automatic drain_pipe();
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GLOBAL: mesh_size    = data;
            CFG_RUN:    run_groups   = data[6:0];
            CFG_CHAIN:  chain_groups = data[6:0];
            default: ;
        endcase
    endtask

    task automatic set_mesh(int unsigned gs, int unsigned rg, int unsigned cg);
        drain_pipe();
        write_reg(CFG_GLOBAL, gs[12:0]);
        write_reg(CFG_RUN, rg[12:0]);
        write_reg(CFG_CHAIN, cg[12:0]);
    endtask

    // Hold one request until accepted; drop valid only for a gap
    task automatic send_request(logic [1:0] req, logic [11:0] rank, logic [5:0] ri,
                                logic [5:0] ci, logic [11:0] li);
        int gap;
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_flat_rank   <= rank;
        i_run_index   <= ri;
        i_chain_index <= ci;
        i_local_index <= li;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 2) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Mostly well-formed requests for the current split, some noise
    task automatic random_request();
        int unsigned rg, cg, span, roll;
        logic [1:0]  req;
        logic [11:0] rank, li;
        logic [5:0]  ri, ci;
        rg = (run_groups == 0) ? 1 : ((run_groups > 64) ? 64 : run_groups);
        cg = (chain_groups == 0) ? 1 : ((chain_groups > 64) ? 64 : chain_groups);
        span = mesh_size / (rg * cg) + 1;
        if (span > 4095)
            span = 4095;
        roll = $urandom_range(0, 99);
        req  = (roll < 6) ? 2'd3 : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 15) begin
            rank = 12'($urandom);
            ri   = 6'($urandom);
            ci   = 6'($urandom);
            li   = 12'($urandom);
        end else begin
            rank = 12'($urandom_range(0, (mesh_size == 0) ? 0 :
                                         ((mesh_size > 4096) ? 4095 : mesh_size - 1)));
            ri   = 6'($urandom_range(0, rg - 1));
            ci   = 6'($urandom_range(0, cg - 1));
            li   = 12'($urandom_range(0, span));
        end
        send_request(req, rank, ri, ci, li);
    endtask

    task automatic random_phase(int n);
        repeat (n) random_request();
        i_in_valid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset split: one rank, one run, one chain
        send_request(REQ_LOCATE, 12'd0, 6'd0, 6'd0, 12'd0);
        send_request(REQ_SIZE, 12'd0, 6'd0, 6'd0, 12'd0);
        random_phase(60);

        // Directed: uneven split of 100 ranks over 7 runs and 3 chains
        set_mesh(100, 7, 3);
        send_request(REQ_LOCATE, 12'd0, 6'd0, 6'd0, 12'd0);
        send_request(REQ_LOCATE, 12'd99, 6'd0, 6'd0, 12'd0);
        send_request(REQ_LOCATE, 12'd100, 6'd0, 6'd0, 12'd0);
        send_request(REQ_LOCATE, 12'd4095, 6'd63, 6'd63, 12'd4095);
        send_request(REQ_LOCATE, 12'd15, 6'd0, 6'd0, 12'd0);
        send_request(REQ_RANK, 12'd0, 6'd0, 6'd0, 12'd0);
        send_request(REQ_RANK, 12'd0, 6'd6, 6'd2, 12'd3);
        send_request(REQ_RANK, 12'd0, 6'd6, 6'd2, 12'd4);
        send_request(REQ_RANK, 12'd0, 6'd7, 6'd0, 12'd0);
        send_request(REQ_RANK, 12'd0, 6'd0, 6'd3, 12'd0);
        send_request(REQ_RANK, 12'd0, 6'd63, 6'd63, 12'd4095);
        send_request(REQ_RANK, 12'd0, 6'd1, 6'd1, 12'd4095);
        send_request(REQ_SIZE, 12'd0, 6'd0, 6'd0, 12'd0);
        send_request(REQ_SIZE, 12'd0, 6'd6, 6'd2, 12'd0);
        send_request(REQ_SIZE, 12'd0, 6'd7, 6'd0, 12'd0);
        send_request(REQ_SIZE, 12'd0, 6'd0, 6'd63, 12'd0);
        send_request(2'd3, 12'd0, 6'd0, 6'd0, 12'd0);
        send_request(2'd3, 12'd4095, 6'd63, 6'd63, 12'd4095);
        random_phase(PHASE_ITEMS);

        // Largest mesh, finest and coarsest splits
        set_mesh(4096, 64, 64);
        send_request(REQ_LOCATE, 12'd4095, 6'd0, 6'd0, 12'd0);
        send_request(REQ_RANK, 12'd0, 6'd63, 6'd63, 12'd0);
        random_phase(PHASE_ITEMS);
        set_mesh(4096, 1, 1);
        send_request(REQ_RANK, 12'd0, 6'd0, 6'd0, 12'd4095);
        send_request(REQ_SIZE, 12'd0, 6'd0, 6'd0, 12'd0);
        random_phase(PHASE_ITEMS);

        // Fewer ranks than groups: empty chain groups
        set_mesh(10, 64, 64);
        random_phase(PHASE_ITEMS);
        set_mesh(70, 5, 64);
        random_phase(PHASE_ITEMS);

        // Bad splits, plus a write to the unused register index
        set_mesh(0, 3, 3);
        random_phase(40);
        set_mesh(8191, 3, 3);
        random_phase(40);
        set_mesh(50, 0, 3);
        random_phase(40);
        set_mesh(50, 127, 3);
        random_phase(40);
        set_mesh(50, 3, 65);
        random_phase(40);
        drain_pipe();
        write_reg(2'd3, 13'h1fff);
        set_mesh(4097, 2, 2);
        random_phase(40);

        // Random good splits
        repeat (6) begin
            set_mesh($urandom_range(1, 4096), $urandom_range(1, 64), $urandom_range(1, 64));
            drain_pipe();
            write_reg(2'd3, 13'($urandom));
            random_phase(PHASE_ITEMS);
        end

        drain_pipe();
        if (fail_count == 0)
            $display("balanced_rank_mesh_mapper: match");
        else
            $display("balanced_rank_mesh_mapper: mismatch");
        $finish;
    end
endmodule
